[sv/ndi_pkg.sv]
// Shared types, constants and saturation helper for the Newton difference interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ndi_pkg;

  localparam int unsigned DefMaxPoints = 16;
  localparam int unsigned DefFracBits  = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_POINTS    = 2'd1,
    ST_ZERO_SPACING = 2'd2
  } status_e;

  // Control broadcast to every cell of the difference chain.
  typedef struct packed {
    logic copy;
    logic step;
    logic back;
  } cell_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/ndi_in_if.sv]
// Request channel: action, coordinate and sample value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface ndi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] coord;
  logic signed [31:0] sample_value;

  modport source (output valid, action, coord, sample_value, input ready);
  modport sink   (input valid, action, coord, sample_value, output ready);
endinterface
`default_nettype wire

[sv/ndi_out_if.sv]
// Result channel: interpolated value, formula flag and status with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface ndi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic               used_backward;
  logic [1:0]         status;

  modport source (output valid, interp_value, used_backward, status, input ready);
  modport sink   (input valid, interp_value, used_backward, status, output ready);
endinterface
`default_nettype wire

[sv/newton_difference_interpolator.sv]
// Top level of the Newton forward/backward difference interpolator.
`timescale 1ns / 1ps
`default_nettype none
// Usage: requests arrive on in_i (valid/ready). A clear item empties the
// sample set, a load item appends (x, y) unless the set is full, and an
// evaluate item returns one result item on out_o with the interpolated
// value, the formula used and a status code. Clear and load leave the
// sequencer idle. Evaluate runs a sequencer over a chain of MAX_POINTS cells
// that form the difference table in place, one difference order per step.
// It runs the scaled-offset division first, DW = 33 + FRAC_BITS quotient
// bits long, and each of the n-1 steps holds the 32-bit short-mode division
// of the series term by the step index in the shared bit-serial divider;
// the offset and the terms are Q16.16 with the default FRAC_BITS of 16.
// No points, a single point or zero spacing finish without a division.
// One item is worked on at a time; in_i.ready is high only while the
// sequencer is idle. The result waits in an output register; if the
// receiver stalls, loads and clears are still taken, and a following
// evaluate holds its result until the register is free.
// Reset empties the sample set and clears both channels; the sample
// memory and the cells hold no defined contents until loaded.
module newton_difference_interpolator #(
  parameter int unsigned MAX_POINTS = ndi_pkg::DefMaxPoints,
  parameter int unsigned FRAC_BITS  = ndi_pkg::DefFracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ndi_in_if.sink    in_i,
  ndi_out_if.source out_o
);
  import ndi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW = 33 + FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RX0  = 4'd1;
  localparam logic [3:0] S_RX1  = 4'd2;
  localparam logic [3:0] S_RXM  = 4'd3;
  localparam logic [3:0] S_RXL  = 4'd4;
  localparam logic [3:0] S_PDIV = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_TSH  = 4'd8;
  localparam logic [3:0] S_TDIV = 4'd9;
  localparam logic [3:0] S_MUL2 = 4'd10;
  localparam logic [3:0] S_ACC  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q;
  logic [AW-1:0]      j_q;
  logic signed [31:0] q_q, x0_q, h_q, p_q, term_q, acc_q;
  logic               back_q, pneg_q, tneg_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] res_val_q;
  logic               res_back_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q;
  logic signed [31:0] out_val_q;
  logic               out_back_q;
  logic [1:0]         out_st_q;

  logic signed [31:0] xmem [MAX_POINTS];
  logic signed [31:0] rd_data_q;
  logic [AW-1:0]      rd_addr;

  logic               accept, do_load, out_free;
  logic [AW-1:0]      half_idx, nm1;
  logic signed [31:0] y_w [MAX_POINTS];
  logic signed [31:0] d_w [MAX_POINTS];
  logic [MAX_POINTS-1:0] cell_we;
  cell_ctrl_t         cell_ctrl;

  logic signed [31:0] h_new, base, y_last, del, factor, mul_b, t_sh, acc_new, p_sat;
  logic signed [32:0] off_diff;
  logic [32:0]        off_abs;
  logic signed [33:0] p_ext, off_ext;
  logic [AW-1:0]      j_m1;
  logic [31:0]        t_abs, quo_lo;

  logic               div_start, div_short, div_done;
  logic [DW-1:0]      div_dvd, div_quo;
  logic [31:0]        div_dvs;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign do_load  = accept && (action_e'(in_i.action) == ACT_LOAD) &&
                    (cnt_q < CW'(MAX_POINTS));
  assign out_free = !out_valid_q || out_o.ready;
  assign half_idx = AW'(cnt_q >> 1);
  assign nm1      = AW'(cnt_q - CW'(1));

  // Sample x memory: one write port for loads, one registered read port.
  always_comb begin
    unique case (state_q)
      S_RX0:   rd_addr = AW'(1);
      S_RX1:   rd_addr = half_idx;
      S_RXM:   rd_addr = nm1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      xmem[cnt_q[AW-1:0]] <= in_i.coord;
    end
    rd_data_q <= xmem[rd_addr];
  end

  // Difference chain.
  assign cell_ctrl.copy = (state_q == S_RXL);
  assign cell_ctrl.step = (state_q == S_DIFF);
  assign cell_ctrl.back = back_q;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic signed [31:0] d_left, d_right;
    assign cell_we[i] = do_load && (cnt_q == CW'(i));
    if (i == 0) begin : g_first
      assign d_left = '0;
    end else begin : g_left
      assign d_left = d_w[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_last
      assign d_right = '0;
    end else begin : g_right
      assign d_right = d_w[i+1];
    end
    ndi_cell u_cell (
      .clk_i     (clk_i),
      .we_i      (cell_we[i]),
      .y_i       (in_i.sample_value),
      .ctrl_i    (cell_ctrl),
      .d_left_i  (d_left),
      .d_right_i (d_right),
      .y_o       (y_w[i]),
      .d_o       (d_w[i])
    );
  end

  // Datapath.
  assign h_new    = sat32(66'(rd_data_q) - 66'(x0_q));
  assign base     = back_q ? rd_data_q : x0_q;
  assign y_last   = y_w[nm1];
  assign del      = back_q ? d_w[nm1] : d_w[0];
  assign off_diff = 33'(q_q) - 33'(base);
  assign off_abs  = off_diff[32] ? 33'(-off_diff) : 33'(off_diff);

  assign j_m1    = j_q - AW'(1);
  assign p_ext   = 34'(p_q);
  assign off_ext = $signed(34'({j_m1, {FRAC_BITS{1'b0}}}));
  assign factor  = sat32(66'(back_q ? p_ext + off_ext : p_ext - off_ext));
  assign mul_b   = (state_q == S_MUL1) ? factor : del;
  assign t_sh    = sat32(66'(prod_q >>> FRAC_BITS));
  assign t_abs   = t_sh[31] ? 32'(~t_sh + 32'sd1) : 32'(t_sh);
  assign acc_new = sat32(66'(acc_q) + 66'(t_sh));
  assign quo_lo  = div_quo[31:0];

  always_comb begin
    if (pneg_q) begin
      p_sat = (div_quo > DW'(33'h080000000)) ? 32'sh80000000 : $signed(~quo_lo + 32'd1);
    end else begin
      p_sat = (div_quo > DW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo_lo);
    end
  end

  assign div_start = (state_q == S_RXL) || (state_q == S_TSH);
  assign div_short = (state_q == S_TSH);
  assign div_dvd   = (state_q == S_TSH) ? DW'(t_abs) : {off_abs, {FRAC_BITS{1'b0}}};
  assign div_dvs   = (state_q == S_TSH) ? 32'(j_q) :
                     (h_q[31] ? 32'(-h_q) : 32'(h_q));

  ndi_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .short_i (div_short),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && action_e'(in_i.action) == ACT_EVAL) begin
          state_d = (cnt_q == '0) ? S_DONE : S_RX0;
        end
      end
      S_RX0:  state_d = (cnt_q == CW'(1)) ? S_DONE : S_RX1;
      S_RX1:  state_d = (h_new == '0) ? S_DONE : S_RXM;
      S_RXM:  state_d = S_RXL;
      S_RXL:  state_d = S_PDIV;
      S_PDIV: state_d = div_done ? S_DIFF : S_PDIV;
      S_DIFF: state_d = S_MUL1;
      S_MUL1: state_d = S_TSH;
      S_TSH:  state_d = S_TDIV;
      S_TDIV: state_d = div_done ? S_MUL2 : S_TDIV;
      S_MUL2: state_d = S_ACC;
      S_ACC:  state_d = (j_q == nm1) ? S_DONE : S_DIFF;
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && action_e'(in_i.action) == ACT_CLEAR) begin
        cnt_q <= '0;
      end else if (do_load) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        q_q        <= in_i.coord;
        res_val_q  <= '0;
        res_back_q <= 1'b0;
        res_st_q   <= ST_NO_POINTS;
      end
      S_RX0: begin
        x0_q       <= rd_data_q;
        res_val_q  <= y_w[0];
        res_back_q <= q_q > rd_data_q;
        res_st_q   <= ST_OK;
      end
      S_RX1: begin
        h_q        <= h_new;
        res_val_q  <= '0;
        res_back_q <= 1'b0;
        res_st_q   <= ST_ZERO_SPACING;
      end
      S_RXM: back_q <= q_q > rd_data_q;
      S_RXL: begin
        acc_q  <= back_q ? y_last : y_w[0];
        pneg_q <= off_diff[32] ^ h_q[31];
      end
      S_PDIV: begin
        p_q    <= p_sat;
        term_q <= 32'sd1 <<< FRAC_BITS;
        j_q    <= AW'(1);
      end
      S_MUL1: prod_q <= term_q * mul_b;
      S_TSH:  tneg_q <= t_sh[31];
      S_TDIV: term_q <= tneg_q ? $signed(~quo_lo + 32'd1) : $signed(quo_lo);
      S_MUL2: prod_q <= term_q * mul_b;
      S_ACC: begin
        acc_q      <= acc_new;
        j_q        <= j_q + AW'(1);
        res_val_q  <= acc_new;
        res_back_q <= back_q;
        res_st_q   <= ST_OK;
      end
      S_DONE: begin
        if (out_free) begin
          out_val_q  <= res_val_q;
          out_back_q <= res_back_q;
          out_st_q   <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.interp_value  = out_val_q;
  assign out_o.used_backward = out_back_q;
  assign out_o.status        = out_st_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("sample count above capacity");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_PDIV || state_q == S_TDIV))
    else $error("divider finished outside a wait state");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIFF |-> (cnt_q >= CW'(2) && j_q != '0 && j_q <= nm1))
    else $error("difference step out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |->
      (out_o.interp_value == '0 && !out_o.used_backward))
    else $error("error result carries a value");
`endif

endmodule
`default_nettype wire

[sv/ndi_cell.sv]
// One cell of the difference chain: holds a sample value and its working difference.
`timescale 1ns / 1ps
`default_nettype none
module ndi_cell (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic signed [31:0] y_i,
  input  ndi_pkg::cell_ctrl_t ctrl_i,
  input  logic signed [31:0] d_left_i,
  input  logic signed [31:0] d_right_i,
  output logic signed [31:0] y_o,
  output logic signed [31:0] d_o
);
  import ndi_pkg::*;

  logic signed [31:0] y_q;
  logic signed [31:0] d_q, d_d;

  // All cells update together from old values; cells past the live range
  // hold values that are never read.
  always_comb begin
    d_d = d_q;
    if (ctrl_i.copy) begin
      d_d = y_q;
    end else if (ctrl_i.step) begin
      if (ctrl_i.back) begin
        d_d = sat32(66'(d_q) - 66'(d_left_i));
      end else begin
        d_d = sat32(66'(d_right_i) - 66'(d_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      y_q <= y_i;
    end
    d_q <= d_d;
  end

  assign y_o = y_q;
  assign d_o = d_q;

endmodule
`default_nettype wire

[sv/ndi_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, with a short 32-bit mode.
`timescale 1ns / 1ps
`default_nettype none
module ndi_div #(
  parameter int unsigned DW = 49
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          short_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [31:0]   dvs_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);
  import ndi_pkg::*;

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DW-1:0]   dvd_q, quo_q;
  logic [31:0]     dvs_q;
  logic [31:0]     rem_q;
  logic [32:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= short_i ? CntW'(32) : CntW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // In short mode the dividend sits in the top bits so only 32 steps are run.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= short_i ? {dvd_i[31:0], {(DW-32){1'b0}}} : dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the Newton difference interpolator.
`timescale 1ns / 1ps
module tb_top;
  import ndi_pkg::*;

  localparam int NPTS = 16;
  localparam int FB = 16;
  localparam longint CycleLimit = 64'd3_000_000;

  typedef struct {
    action_e act;
    logic signed [31:0] coord;
    logic signed [31:0] yval;
    logic has_exp;
    logic signed [31:0] exp_val;
    logic exp_back;
    status_e exp_st;
  } req_t;

  typedef struct {
    logic signed [31:0] val;
    logic back;
    status_e st;
  } interp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ndi_in_if in_if ();
  ndi_out_if out_if ();

  newton_difference_interpolator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the sample set.
  logic signed [31:0] xs[NPTS];
  logic signed [31:0] ys[NPTS];
  int npts;
  interp_t pending[$];
  int errors;
  longint cycles;
  bit stim_done;
  bit drain_done;

  function automatic longint sat_to32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift right floors for negative values.
  function automatic longint floor_q(longint v);
    return v >>> FB;
  endfunction

  function automatic interp_t interpolate(logic signed [31:0] q);
    interp_t r;
    longint d[NPTS];
    longint h, base, acc, p, term, del, factor, one;
    int n;
    one = 64'sd1 << FB;
    n = npts;
    r.val = '0;
    r.back = 1'b0;
    r.st = ST_OK;
    if (n == 0) begin
      r.st = ST_NO_POINTS;
    end else if (n == 1) begin
      r.val = ys[0];
      r.back = (q > xs[0]);
    end else begin
      h = sat_to32(longint'(xs[1]) - longint'(xs[0]));
      if (h == 0) begin
        r.st = ST_ZERO_SPACING;
      end else begin
        r.back = (q > xs[n / 2]);
        base = r.back ? longint'(xs[n - 1]) : longint'(xs[0]);
        acc = r.back ? longint'(ys[n - 1]) : longint'(ys[0]);
        p = sat_to32(((longint'(q) - base) * one) / h);
        term = one;
        for (int i = 0; i < n; i++) d[i] = ys[i];
        for (int j = 1; j < n; j++) begin
          if (!r.back) begin
            for (int i = 0; i < n - j; i++) d[i] = sat_to32(d[i + 1] - d[i]);
            del = d[0];
          end else begin
            for (int i = n - 1; i >= j; i--) d[i] = sat_to32(d[i] - d[i - 1]);
            del = d[n - 1];
          end
          factor = sat_to32(r.back ? p + (j - 1) * one : p - (j - 1) * one);
          term = sat_to32(floor_q(term * factor));
          term = term / j;
          acc = sat_to32(acc + sat_to32(floor_q(term * del)));
        end
        r.val = acc[31:0];
      end
    end
    return r;
  endfunction

  // Applies an accepted item to the shadow state and queues any result.
  task automatic track_item(req_t rq);
    interp_t e;
    case (rq.act)
      ACT_CLEAR: npts = 0;
      ACT_LOAD: begin
        if (npts < NPTS) begin
          xs[npts] = rq.coord;
          ys[npts] = rq.yval;
          npts++;
        end
      end
      ACT_EVAL: begin
        e = interpolate(rq.coord);
        if (rq.has_exp && (e.val !== rq.exp_val || e.back !== rq.exp_back ||
                           e.st !== rq.exp_st)) begin
          $error("table row disagrees with predictor at coord %0d", rq.coord);
          errors++;
        end
        pending.push_back(e);
      end
      default: ;
    endcase
  endtask

  // Valid stays high after an accept unless a gap follows, so that valid
  // never gets two updates at one edge.
  task automatic send_item(req_t rq);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= rq.act;
    in_if.coord <= rq.coord;
    in_if.sample_value <= rq.yval;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    track_item(rq);
  endtask

  function automatic req_t mk(action_e a, logic signed [31:0] c, logic signed [31:0] y);
    req_t r;
    r.act = a;
    r.coord = c;
    r.yval = y;
    r.has_exp = 1'b0;
    r.exp_val = '0;
    r.exp_back = 1'b0;
    r.exp_st = ST_OK;
    return r;
  endfunction

  function automatic req_t mk_exp(logic signed [31:0] c, logic signed [31:0] v, logic b,
                                  status_e s);
    req_t r;
    r = mk(ACT_EVAL, c, $urandom);
    r.has_exp = 1'b1;
    r.exp_val = v;
    r.exp_back = b;
    r.exp_st = s;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Result side: random stall then compare with the oldest prediction.
  initial begin
    interp_t e;
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_if.interp_value !== e.val) begin
          $error("interp_value expected %0d got %0d", e.val, out_if.interp_value);
          errors++;
        end
        if (out_if.used_backward !== e.back) begin
          $error("used_backward expected %0b got %0b", e.back, out_if.used_backward);
          errors++;
        end
        if (out_if.status !== e.st) begin
          $error("status expected %0d got %0d", e.st, out_if.status);
          errors++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    req_t dir[$];
    int count, n, mode;
    logic signed [31:0] x0, h;
    bit held;
    errors = 0;
    npts = 0;
    held = 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_NONE;
    in_if.coord <= '0;
    in_if.sample_value <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty set, single point, zero spacing, extremes, overfull set.
    dir.push_back(mk_exp(32'sh7FFFFFFF, 0, 1'b0, ST_NO_POINTS));
    dir.push_back(mk(ACT_NONE, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    dir.push_back(mk(ACT_LOAD, 32'sh0001_0000, 32'sh0005_0000));
    dir.push_back(mk_exp(32'sh0002_0000, 32'sh0005_0000, 1'b1, ST_OK));
    dir.push_back(mk_exp(32'sh0001_0000, 32'sh0005_0000, 1'b0, ST_OK));
    dir.push_back(mk(ACT_LOAD, 32'sh0001_0000, 32'sh80000000));
    dir.push_back(mk_exp(32'sh80000000, 0, 1'b0, ST_ZERO_SPACING));
    dir.push_back(mk(ACT_CLEAR, 32'sh80000000, 32'sh80000000));
    dir.push_back(mk_exp(0, 0, 1'b0, ST_NO_POINTS));
    dir.push_back(mk(ACT_LOAD, 32'sh80000000, 32'sh80000000));
    dir.push_back(mk(ACT_LOAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    dir.push_back(mk(ACT_LOAD, 32'sh0000_0000, 32'sh7FFFFFFF));
    dir.push_back(mk(ACT_EVAL, 32'sh7FFFFFFF, 0));
    dir.push_back(mk(ACT_EVAL, 32'sh80000000, 0));
    dir.push_back(mk(ACT_CLEAR, 0, 0));
    for (int i = 0; i < NPTS + 1; i++) dir.push_back(mk(ACT_LOAD, i <<< 16, (i * i) <<< 14));
    dir.push_back(mk(ACT_EVAL, 32'sh0003_8000, 0));
    dir.push_back(mk(ACT_EVAL, 32'sh000C_4000, 0));
    foreach (dir[i]) send_item(dir[i]);
    count = dir.size();

    while (count < 1100) begin
      // Mostly a fresh set of equally spaced points, then several queries.
      mode = $urandom_range(0, 9);
      send_item(mk(ACT_CLEAR, rnd_word(), rnd_word()));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NPTS + 2) : $urandom_range(0, 6);
      x0 = (mode == 0) ? rnd_word() : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      h = (mode == 1) ? 0 : (mode == 2) ? rnd_word()
          : $signed($urandom_range(32'h0000_4000, 32'h0004_0000)) * (($urandom & 1) ? 1 : -1);
      for (int i = 0; i < n; i++)
        send_item(mk(ACT_LOAD, x0 + i * h, (mode == 3) ? rnd_word()
                     : $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000));
      for (int k = $urandom_range(1, 5); k > 0; k--) begin
        if ($urandom_range(0, 9) == 0)
          send_item(mk(action_e'($urandom_range(0, 3)), rnd_word(), rnd_word()));
        else
          send_item(mk(ACT_EVAL, (mode == 4) ? rnd_word()
                       : x0 + $signed($urandom_range(0, 6 * 32'h0004_0000)), rnd_word()));
        count++;
      end
      count += n + 1;
      if (!held && count > 500) begin
        // Hold the sender until the result side has caught up.
        held = 1'b1;
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending.size() != 0) @(posedge clk_i);
      end
    end

    in_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
